@@ src/nand_command_address_sequencer_top_assert.svh @@
// Assertion helpers for the NAND command/address sequencer.
// Each one is clocked on clk and disabled while rst_n is low.
`ifndef NAND_COMMAND_ADDRESS_SEQUENCER_TOP_ASSERT_SVH
`define NAND_COMMAND_ADDRESS_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication
`define NACS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NACS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nacs_pkg.sv @@
package nacs_pkg;

    // Result slots in one job
    localparam int MAX_RESULTS = 7;
    localparam int POS_W       = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 24;
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int BCNT_W  = 18;

    // Cycle kinds
    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_RESET      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_STATUS     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_ID    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAGE_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ERASE      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PROG_START = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_PROG_CONF  = 3'd6;

    // NAND command bytes
    localparam logic [BYTE_W-1:0] CMD_READ0     = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READSTART = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_ERASE1    = 8'h60;
    localparam logic [BYTE_W-1:0] CMD_ERASE2    = 8'hd0;
    localparam logic [BYTE_W-1:0] CMD_SEQIN     = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_PAGEPROG  = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_STATUS    = 8'h70;
    localparam logic [BYTE_W-1:0] CMD_RESET     = 8'hff;
    localparam logic [BYTE_W-1:0] CMD_READID    = 8'h90;
    localparam logic [BYTE_W-1:0] ADDR_ZERO     = 8'h00;

    // Register indices
    localparam logic [1:0] REG_SMALL_PAGES   = 2'd0;
    localparam logic [1:0] REG_MANY_ADDR     = 2'd1;
    localparam logic [1:0] REG_NORMAL_BLOCKS = 2'd2;
    localparam logic [1:0] REG_BLOCK_COUNT   = 2'd3;

    // Geometry configuration
    typedef struct packed {
        logic              small_pages;
        logic              many_address_cycles;
        logic              normal_blocks;
        logic [BCNT_W-1:0] num_blocks;
    } cfg_t;

    // One classified request: its result list
    typedef struct packed {
        logic [MAX_RESULTS-1:0][KIND_W-1:0] kind;
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
        logic [POS_W-1:0]                   last_pos;
        logic                               err;
    } job_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/nacs_front.sv @@
module nacs_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [nacs_pkg::FUNC_W-1:0]  func,
    input  logic [nacs_pkg::INDEX_W-1:0] index,
    input  nacs_pkg::cfg_t           cfg,
    input  nacs_pkg::q_status_t      q_status,
    output logic                     push,
    output nacs_pkg::job_t           job
);
    import nacs_pkg::*;

    logic [2:0]         shift;
    logic [INDEX_W:0]   pages;
    logic               page_err;
    logic               blk_err;
    logic [INDEX_W-1:0] row;
    logic               do_page;

    // Accept whenever the queue has room
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Geometry and range checks
    always_comb
    begin
        if (cfg.small_pages)
            shift = 3'd5;
        else if (cfg.normal_blocks)
            shift = 3'd6;
        else
            shift = 3'd7;
        pages    = {{(INDEX_W + 1 - BCNT_W){1'b0}}, cfg.num_blocks} << shift;
        page_err = {1'b0, index} >= pages;
        blk_err  = index >= {{(INDEX_W - BCNT_W){1'b0}}, cfg.num_blocks};
        row      = index << shift;
    end

    // Build the result list
    always_comb
    begin
        logic [POS_W-1:0] pos;
        pos     = '0;
        job     = '0;
        do_page = 1'b0;
        unique case (func)
            FUNC_RESET:
            begin
                job.kind[pos] = KIND_CMD; job.data[pos] = CMD_RESET; pos = pos + 1'b1;
            end
            FUNC_STATUS:
            begin
                job.kind[pos] = KIND_CMD; job.data[pos] = CMD_STATUS; pos = pos + 1'b1;
            end
            FUNC_READ_ID:
            begin
                job.kind[pos] = KIND_CMD;  job.data[pos] = CMD_READID; pos = pos + 1'b1;
                job.kind[pos] = KIND_ADDR; job.data[pos] = ADDR_ZERO;  pos = pos + 1'b1;
            end
            FUNC_PAGE_READ:
            begin
                if (page_err)
                begin
                    job.kind[pos] = KIND_NONE; pos = pos + 1'b1;
                    job.err = 1'b1;
                end
                else
                begin
                    job.kind[pos] = KIND_CMD; job.data[pos] = CMD_READ0; pos = pos + 1'b1;
                    if (!cfg.small_pages)
                    begin
                        job.kind[pos] = KIND_CMD; job.data[pos] = CMD_READSTART;
                        pos = pos + 1'b1;
                    end
                    do_page = 1'b1;
                end
            end
            FUNC_ERASE:
            begin
                if (blk_err)
                begin
                    job.kind[pos] = KIND_NONE; pos = pos + 1'b1;
                    job.err = 1'b1;
                end
                else
                begin
                    job.kind[pos] = KIND_CMD;  job.data[pos] = CMD_ERASE1; pos = pos + 1'b1;
                    job.kind[pos] = KIND_ADDR; job.data[pos] = row[7:0];   pos = pos + 1'b1;
                    job.kind[pos] = KIND_ADDR; job.data[pos] = row[15:8];  pos = pos + 1'b1;
                    if (cfg.many_address_cycles)
                    begin
                        job.kind[pos] = KIND_ADDR; job.data[pos] = row[23:16];
                        pos = pos + 1'b1;
                    end
                    job.kind[pos] = KIND_CMD;  job.data[pos] = CMD_ERASE2; pos = pos + 1'b1;
                end
            end
            FUNC_PROG_START:
            begin
                if (page_err)
                begin
                    job.kind[pos] = KIND_NONE; pos = pos + 1'b1;
                    job.err = 1'b1;
                end
                else
                begin
                    job.kind[pos] = KIND_CMD; job.data[pos] = CMD_SEQIN; pos = pos + 1'b1;
                    do_page = 1'b1;
                end
            end
            FUNC_PROG_CONF:
            begin
                job.kind[pos] = KIND_CMD; job.data[pos] = CMD_PAGEPROG; pos = pos + 1'b1;
                job.kind[pos] = KIND_CMD; job.data[pos] = CMD_STATUS;   pos = pos + 1'b1;
            end
            default:
            begin
                job.kind[pos] = KIND_NONE; pos = pos + 1'b1;
            end
        endcase
        // Column bytes then row bytes, low first
        if (do_page)
        begin
            job.kind[pos] = KIND_ADDR; job.data[pos] = ADDR_ZERO; pos = pos + 1'b1;
            if (!cfg.small_pages)
            begin
                job.kind[pos] = KIND_ADDR; job.data[pos] = ADDR_ZERO; pos = pos + 1'b1;
            end
            job.kind[pos] = KIND_ADDR; job.data[pos] = index[7:0];  pos = pos + 1'b1;
            job.kind[pos] = KIND_ADDR; job.data[pos] = index[15:8]; pos = pos + 1'b1;
            if (cfg.many_address_cycles)
            begin
                job.kind[pos] = KIND_ADDR; job.data[pos] = index[23:16];
                pos = pos + 1'b1;
            end
        end
        job.last_pos = pos - 1'b1;
    end

endmodule

@@ src/nacs_queue.sv @@
module nacs_queue #(
    parameter int DEPTH = nacs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nacs_pkg::job_t      push_job,
    input  logic                pop,
    output nacs_pkg::job_t      head,
    output nacs_pkg::q_status_t status
);
    import nacs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = count_reg == CNT_FULL;
    assign status.empty = count_reg == '0;
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ src/nacs_back.sv @@
module nacs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nacs_pkg::job_t               head,
    input  nacs_pkg::q_status_t          q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nacs_pkg::KIND_W-1:0]  cycle_kind,
    output logic [nacs_pkg::BYTE_W-1:0]  bus_byte,
    output logic                         last,
    output logic                         range_error
);
    import nacs_pkg::*;

    logic [POS_W-1:0]  step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              err_reg;
    logic              load;
    logic              is_last;

    // One bus cycle per clock while a job is queued and the output register is free
    assign load    = !q_status.empty && (!out_valid_reg || out_ready);
    assign is_last = step_reg == head.last_pos;
    assign pop     = load && is_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = is_last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head.kind[step_reg];
            byte_reg <= head.data[step_reg];
            last_reg <= is_last;
            err_reg  <= head.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cycle_kind  = kind_reg;
    assign bus_byte    = byte_reg;
    assign last        = last_reg;
    assign range_error = err_reg;

endmodule

@@ src/nand_command_address_sequencer_top.sv @@
// NAND command/address sequencer. Each request (func, index) is expanded into
// the command and address bus bytes of that operation, 1 to 7 results, sent as
// transactions on the out channel with last set on the final one. The output
// register of the back end issues one bus byte per clock while the queue holds
// a job and out_ready does not stall it. Requests are classified when accepted
// and held in a QUEUE_DEPTH-entry job queue (default two), so in_ready stays
// high while a result waits, until that queue is full. Each request is stored
// in the queue, then in the output register, before its first result appears.
// Geometry registers sit on the APB port at byte addresses 0, 4, 8 and 12; the
// user must write them only while no request is in flight (block: unenforced).
`include "nand_command_address_sequencer_top_assert.svh"

module nand_command_address_sequencer_top #(
    parameter int QUEUE_DEPTH = nacs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nacs_pkg::FUNC_W-1:0]   func,
    input  logic [nacs_pkg::INDEX_W-1:0]  index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nacs_pkg::KIND_W-1:0]   cycle_kind,
    output logic [nacs_pkg::BYTE_W-1:0]   bus_byte,
    output logic                          last,
    output logic                          range_error
);
    import nacs_pkg::*;

    cfg_t      cfg_reg;
    logic      cfg_wr;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head;
    q_status_t q_status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_pages         <= 1'b0;
            cfg_reg.many_address_cycles <= 1'b0;
            cfg_reg.normal_blocks       <= 1'b1;
            cfg_reg.num_blocks          <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SMALL_PAGES:   cfg_reg.small_pages         <= pwdata[0];
                REG_MANY_ADDR:     cfg_reg.many_address_cycles <= pwdata[0];
                REG_NORMAL_BLOCKS: cfg_reg.normal_blocks       <= pwdata[0];
                REG_BLOCK_COUNT:   cfg_reg.num_blocks          <= pwdata[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SMALL_PAGES:   prdata[0] = cfg_reg.small_pages;
            REG_MANY_ADDR:     prdata[0] = cfg_reg.many_address_cycles;
            REG_NORMAL_BLOCKS: prdata[0] = cfg_reg.normal_blocks;
            REG_BLOCK_COUNT:   prdata[BCNT_W-1:0] = cfg_reg.num_blocks;
            default: ;
        endcase
    end

    nacs_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .index    (index),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    nacs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    nacs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cycle_kind  (cycle_kind),
        .bus_byte    (bus_byte),
        .last        (last),
        .range_error (range_error)
    );

    // Checks
    `NACS_ASSERT_IMP(a_err_shape, out_valid && range_error, last && (cycle_kind == KIND_NONE) && (bus_byte == '0), "range error result malformed")
    `NACS_ASSERT_IMP(a_none_last, out_valid && (cycle_kind == KIND_NONE), last, "no-cycle result not last")
    `NACS_ASSERT_NXT(a_no_bubble, out_valid && out_ready && !last, out_valid, "gap inside a sequence")

endmodule
